/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A condition that, when true, must be accompanied by a consequence.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* sv/srtra_pkg.sv */
// ---------------------------------------------------------------------------
// srtra_pkg
// Types, constants and helpers shared by the radix-to-ASCII converter.
// ---------------------------------------------------------------------------
package srtra_pkg;

    localparam int RADIX_W = 6;
    localparam int DIGIT_W = 5;
    localparam int CHAR_W  = 8;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] MIN_RADIX   = 6'd2;
    localparam logic [RADIX_W-1:0] MAX_RADIX   = 6'd32;
    localparam logic [RADIX_W-1:0] SIGN_RADIX  = 6'd10;

    localparam logic [CHAR_W-1:0] LETTER_BASE = 8'd65;
    localparam logic [CHAR_W-1:0] DIGIT_BASE  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NULL   = 8'h00;
    localparam logic [CHAR_W-1:0] DIGIT_TEN   = 8'd10;

    // Register index of the radix register.
    localparam logic REG_RADIX = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_FETCH,
        ST_LOAD,
        ST_BAD
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (dx >= DIGIT_TEN)
        begin
            return LETTER_BASE + dx - DIGIT_TEN;
        end
        return DIGIT_BASE + dx;
    endfunction

endpackage

/* sv/srtra_div.sv */
// ---------------------------------------------------------------------------
// srtra_div
// Restoring divider by a small radix, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module srtra_div
    import srtra_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] dividend,
    input  logic [RADIX_W-1:0]    divisor,
    output logic [DATA_WIDTH-1:0] quotient,
    output logic [DIGIT_W-1:0]    remainder,
    output div_status_t           status
);

    localparam int CNT_W = $clog2(DATA_WIDTH + 1);

    logic [DATA_WIDTH-1:0] work_reg, work_next;
    logic [DIGIT_W-1:0]    rem_reg, rem_next;
    logic [RADIX_W-1:0]    divisor_reg;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [RADIX_W-1:0]    rem_shift;
    logic                  fits;

    // One restoring step: bring down the next dividend bit and try a subtract.
    // The partial remainder stays below the divisor, so it fits in a digit.
    assign rem_shift = {rem_reg, work_reg[DATA_WIDTH-1]};
    assign fits      = (rem_shift >= divisor_reg);

    always_comb
    begin
        work_next = work_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            work_next = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(DATA_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            work_next = {work_reg[DATA_WIDTH-2:0], fits};
            rem_next  = fits ? DIGIT_W'(rem_shift - divisor_reg) : rem_shift[DIGIT_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        if (start)
        begin
            divisor_reg <= divisor;
        end
    end

    assign quotient    = work_reg;
    assign remainder   = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

/* sv/srtra_digit_buf.sv */
// ---------------------------------------------------------------------------
// srtra_digit_buf
// Digit store: digits are written least significant first, read back in reverse.
// ---------------------------------------------------------------------------
module srtra_digit_buf
    import srtra_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DIGIT_W-1:0]       wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DIGIT_W-1:0]       rd_data
);

    logic [DIGIT_W-1:0] mem [DEPTH];
    logic [DIGIT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/signed_to_radix_ascii.sv */
// ---------------------------------------------------------------------------
// signed_to_radix_ascii
// Converts a signed integer into its ASCII text in a programmable radix.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Payload                          Handshake
//  s_axis    in         value (DATA_WIDTH bits, signed)  s_tvalid / s_tready
//  m_axis    out        character, last, bad_base        m_tvalid / m_tready
//  apb       in/out     radix register at address 0      psel / penable / pready
//
//  Each digit is produced by one pass of the shared restoring divider, until
//  the quotient reaches zero. The digits are then read back out of the digit
//  store, each by a fetch and a load step, most significant first, after a
//  minus sign for a negative value in radix 10. Reset is asynchronous and
//  active low; it sets the radix to 10 and empties the output register. A
//  stalled output holds the sequencer in place; the input is taken again
//  only once the final character sits in the output register.
// ---------------------------------------------------------------------------
module signed_to_radix_ascii
    import srtra_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Input stream. tdata: value [DATA_WIDTH-1:0], zero padding above.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [((DATA_WIDTH+7)/8)*8-1:0]   s_tdata,
    // Output stream. tdata: character [7:0]. tlast: last. tuser: bad_base.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,
    output logic                              m_tlast,
    output logic                              m_tuser,
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    `include "assert_macros.svh"

    localparam int CNT_W = $clog2(DATA_WIDTH + 1);
    localparam int IDX_W = $clog2(DATA_WIDTH);

    // ---------------------------------------------------------------------
    // Configuration register. Only the register index (address bit 2) is
    // decoded; the low address bits select nothing.
    // ---------------------------------------------------------------------
    logic [RADIX_W-1:0] radix_reg;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_RADIX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (cfg_write)
        begin
            radix_reg <= pwdata[RADIX_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_RADIX) ? {{(32-RADIX_W){1'b0}}, radix_reg} : '0;

    // ---------------------------------------------------------------------
    // Input decode: sign and magnitude. The most negative value negates to
    // itself, which read as unsigned is exactly its magnitude.
    // ---------------------------------------------------------------------
    logic [DATA_WIDTH-1:0] in_value;
    logic [DATA_WIDTH-1:0] in_mag;
    logic                  in_accept;
    logic                  radix_ok;

    assign in_value  = s_tdata[DATA_WIDTH-1:0];
    assign in_mag    = in_value[DATA_WIDTH-1] ? (~in_value + 1'b1) : in_value;
    assign in_accept = s_tvalid && s_tready;
    assign radix_ok  = (radix_reg >= MIN_RADIX) && (radix_reg <= MAX_RADIX);

    // ---------------------------------------------------------------------
    // Sequencer state and shared units.
    // ---------------------------------------------------------------------
    state_t                state_reg, state_next;
    logic                  neg_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [IDX_W-1:0]      rd_idx_reg, rd_idx_next;

    logic                  div_start;
    logic [DATA_WIDTH-1:0] div_dividend;
    logic [DATA_WIDTH-1:0] div_quotient;
    logic [DIGIT_W-1:0]    div_remainder;
    div_status_t           div_stat;
    logic                  conv_done;

    logic                  buf_rd_en;
    logic [DIGIT_W-1:0]    buf_rd_data;

    logic                  out_free;
    logic                  out_load;
    logic [CHAR_W-1:0]     out_char;
    logic                  out_last;
    logic                  out_bad;

    logic                  m_tvalid_reg;
    logic [CHAR_W-1:0]     m_tdata_reg;
    logic                  m_tlast_reg;
    logic                  m_tuser_reg;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign conv_done = (state_reg == ST_DIV) && div_stat.done && (div_quotient == '0);

    // The first division works on the fresh magnitude, every later one on the
    // quotient the divider left behind.
    assign div_dividend = (state_reg == ST_IDLE) ? in_mag : div_quotient;
    assign div_start    = ((state_reg == ST_IDLE) && in_accept && radix_ok)
                        || ((state_reg == ST_DIV) && div_stat.done && (div_quotient != '0));

    srtra_div #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (radix_reg),
        .quotient  (div_quotient),
        .remainder (div_remainder),
        .status    (div_stat)
    );

    srtra_digit_buf #(
        .DEPTH (DATA_WIDTH)
    ) u_buf (
        .clk     (clk),
        .wr_en   ((state_reg == ST_DIV) && div_stat.done),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (div_remainder),
        .rd_en   (buf_rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (buf_rd_data)
    );

    // ---------------------------------------------------------------------
    // Next-state logic.
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = radix_ok ? ST_DIV : ST_BAD;
                end
            end
            ST_DIV:
            begin
                if (conv_done)
                begin
                    state_next = (neg_reg && (radix_reg == SIGN_RADIX)) ? ST_SIGN : ST_FETCH;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    state_next = (rd_idx_reg == '0) ? ST_IDLE : ST_FETCH;
                end
            end
            ST_BAD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Output logic of the sequencer.
    // ---------------------------------------------------------------------
    always_comb
    begin
        s_tready    = 1'b0;
        buf_rd_en   = 1'b0;
        out_load    = 1'b0;
        out_char    = CHAR_NULL;
        out_last    = 1'b0;
        out_bad     = 1'b0;
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                count_next = '0;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    count_next = count_reg + 1'b1;
                end
                if (conv_done)
                begin
                    // Digits come out most significant first: start at the top.
                    rd_idx_next = count_reg[IDX_W-1:0];
                end
            end
            ST_SIGN:
            begin
                out_load = out_free;
                out_char = CHAR_MINUS;
            end
            ST_FETCH:
            begin
                buf_rd_en = 1'b1;
            end
            ST_LOAD:
            begin
                out_load = out_free;
                out_char = digit_to_char(buf_rd_data);
                out_last = (rd_idx_reg == '0);
                if (out_free && (rd_idx_reg != '0))
                begin
                    rd_idx_next = rd_idx_reg - 1'b1;
                end
            end
            ST_BAD:
            begin
                out_load = out_free;
                out_char = CHAR_NULL;
                out_last = 1'b1;
                out_bad  = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            rd_idx_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rd_idx_reg <= rd_idx_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            neg_reg <= in_value[DATA_WIDTH-1];
        end
        if (out_load)
        begin
            m_tdata_reg <= out_char;
            m_tlast_reg <= out_last;
            m_tuser_reg <= out_bad;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------
    `ASSERT_IMPLIES(a_bad_is_lone_null, m_tvalid && m_tuser,
        m_tlast && (m_tdata == CHAR_NULL), "bad radix result must be a lone null")
    `ASSERT_IMPLIES(a_div_only_in_div, div_stat.busy || div_stat.done,
        state_reg == ST_DIV, "divider active outside the divide phase")
    `ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(DATA_WIDTH),
        "digit count exceeds the data width")
    `ASSERT_IMPLIES(a_load_needs_room, out_load,
        !m_tvalid_reg || m_tready, "output register overwritten before transfer")

endmodule

/* sim/tb_signed_to_radix_ascii.sv */
// ----------------------------------------------------------------------------
// tb_signed_to_radix_ascii
// Self-checking bench for the signed integer to radix ASCII text converter.
//
// Values go in through the input stream. The bench works out the text that
// each value must produce in the radix currently programmed over APB, and it
// compares every character that leaves the output stream, field by field,
// with the oldest character still awaited. The radix is reprogrammed between
// phases, only after all awaited text has arrived. The phases cover the reset
// radix, the valid extremes and out-of-range settings. Both stream sides idle
// and stall at random.
// ----------------------------------------------------------------------------
module tb_signed_to_radix_ascii;
    timeunit 1ns;
    timeprecision 1ps;

    import srtra_pkg::*;

    localparam int VALUE_W = 32;
    localparam int TDATA_W = ((VALUE_W + 7) / 8) * 8;

    // The radix register is register 0, so it sits at byte address 0.
    localparam logic [2:0] RADIX_ADDR = {REG_RADIX, 2'b00};

    // The timeout is set several times above the slowest legal run. A run has
    // about 360 values. Each value produces up to 32 characters, and each of
    // them can stall. The sender also adds random gaps between values.
    localparam int CYCLE_LIMIT = 2_000_000;

    localparam int RANDOM_VALUES  = 338;
    localparam int MAX_REPORTS    = 40;

    localparam logic [VALUE_W-1:0] INT_MAX = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] INT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
        logic              bad_base;
    } text_char_t;

    // ------------------------------------------------------------------------
    // Text predictor and the store of characters still awaited.
    // ------------------------------------------------------------------------
    class radix_text_scoreboard;
        text_char_t        awaited_chars[$];
        logic [RADIX_W-1:0] radix_q;
        int                errors;
        int                values_noted;
        int                chars_checked;
        int                flagged_results;
        int                minus_signs;

        function new();
            radix_q = RADIX_RESET;
        endfunction

        function void set_radix(logic [RADIX_W-1:0] r);
            radix_q = r;
        endfunction

        function int awaited_count();
            return awaited_chars.size();
        endfunction

        function void report_mismatch(string what, logic [31:0] want, logic [31:0] got);
            errors++;
            if (errors <= MAX_REPORTS)
            begin
                $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            end
        endfunction

        // Builds the text of one value, most significant character first.
        function void note_value(logic [VALUE_W-1:0] value);
            logic [VALUE_W-1:0] mag;
            logic [VALUE_W-1:0] base;
            logic [VALUE_W-1:0] rem;
            logic [CHAR_W-1:0]  digits[$];
            text_char_t         item;
            values_noted++;
            if (radix_q < MIN_RADIX || radix_q > MAX_RADIX)
            begin
                item.character = CHAR_NULL;
                item.last      = 1'b1;
                item.bad_base  = 1'b1;
                awaited_chars.push_back(item);
                return;
            end
            // Negating the most negative value leaves 2^31 in unsigned form,
            // which is the magnitude that the block must use.
            mag  = value[VALUE_W-1] ? (~value + 1'b1) : value;
            base = VALUE_W'(radix_q);
            if (mag == '0)
            begin
                digits.push_front(DIGIT_BASE);
            end
            while (mag != '0)
            begin
                rem = mag % base;
                if (rem >= VALUE_W'(DIGIT_TEN))
                begin
                    digits.push_front(LETTER_BASE + rem[CHAR_W-1:0] - DIGIT_TEN);
                end
                else
                begin
                    digits.push_front(DIGIT_BASE + rem[CHAR_W-1:0]);
                end
                mag = mag / base;
            end
            if (value[VALUE_W-1] && radix_q == SIGN_RADIX)
            begin
                digits.push_front(CHAR_MINUS);
            end
            foreach (digits[i])
            begin
                item.character = digits[i];
                item.last      = (i == digits.size() - 1);
                item.bad_base  = 1'b0;
                awaited_chars.push_back(item);
            end
        endfunction

        function void check_char(logic [CHAR_W-1:0] character, logic last, logic bad_base);
            text_char_t want;
            chars_checked++;
            if (bad_base)
            begin
                flagged_results++;
            end
            if (character == CHAR_MINUS && !bad_base)
            begin
                minus_signs++;
            end
            if (awaited_chars.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                begin
                    $display("%0t ns: character %0h (last %b, bad_base %b) with none awaited",
                             $time, character, last, bad_base);
                end
                return;
            end
            want = awaited_chars.pop_front();
            if (character !== want.character)
            begin
                report_mismatch("character", 32'(want.character), 32'(character));
            end
            if (last !== want.last)
            begin
                report_mismatch("last", 32'(want.last), 32'(last));
            end
            if (bad_base !== want.bad_base)
            begin
                report_mismatch("bad_base", 32'(want.bad_base), 32'(bad_base));
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block itself.
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    logic               s_tvalid;
    logic               s_tready;
    // Fields from bit 0 up: value [31:0].
    logic [TDATA_W-1:0] s_tdata;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    // Fields from bit 0 up: character [7:0].
    logic [7:0]         m_tdata;
    logic               m_tlast;
    // Fields from bit 0 up: bad_base [0].
    logic               m_tuser;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    radix_text_scoreboard board;
    int                   cycle_count = 0;
    int                   burst_left;
    int                   radix_settings;
    int                   stall_left = 0;
    int                   stall_mode = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    signed_to_radix_ascii #(
        .DATA_WIDTH (VALUE_W)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // The run ends here if the block stops making progress.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. The ready line follows a pattern that changes now and then.
    // In one mode it is always high. In another it is random on each cycle.
    // In the third it is mostly high, with occasional stalls.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
        begin
            stall_mode = $urandom_range(0, 2);
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= $urandom_range(0, 1);
                default:
                begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 3) == 0)
                    begin
                        stall_left = $urandom_range(1, 6);
                    end
                end
            endcase
        end
    end

    // Every character transfer is checked against the oldest awaited one.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            board.check_char(m_tdata, m_tlast, m_tuser);
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks.
    // ------------------------------------------------------------------------

    // Offers one value and waits for its transfer. The valid line stays high
    // into the next value while a burst lasts. At the end of a burst it drops
    // for a random gap. Some gaps are long, so that the next value can arrive
    // at any point of the conversion that is in progress.
    task automatic send_value(input logic [VALUE_W-1:0] value);
        int gap;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(value);
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        board.note_value(value);
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 5);
            @(negedge clk);
            s_tvalid <= 1'b0;
            s_tdata  <= TDATA_W'($urandom);
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40)
                                                     : $urandom_range(1, 5);
        end
    endtask

    // Holds the sender back until every awaited character has arrived. The
    // block takes a new value only after the final character of the current
    // one is in its output register, so a short pause after that is enough.
    task automatic drain_text();
        if (s_tvalid)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        while (board.awaited_count() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // One APB transfer with a setup and an access cycle. It returns the read
    // data that is sampled at the access edge.
    task automatic apb_access(input logic write, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Programs the radix with random upper bits, which the register must
    // drop. The value is then read back.
    task automatic set_radix(input logic [RADIX_W-1:0] r);
        logic [31:0] noise;
        logic [31:0] rdata;
        drain_text();
        noise = $urandom;
        apb_access(1'b1, RADIX_ADDR, {noise[31:RADIX_W], r}, rdata);
        board.set_radix(r);
        radix_settings++;
        apb_access(1'b0, RADIX_ADDR, $urandom, rdata);
        if (rdata[RADIX_W-1:0] !== r)
        begin
            board.report_mismatch("radix readback", 32'(r), 32'(rdata[RADIX_W-1:0]));
        end
    endtask

    // Random values that are weighted toward the cases that matter. These are
    // full-range, 16-bit and shifted words, small numbers, both extremes, and
    // powers of the radix or one below them, which are where the digit count changes.
    function automatic logic [VALUE_W-1:0] random_value(input logic [RADIX_W-1:0] r);
        logic [63:0]        power;
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 7))
            0, 1, 2: v = $urandom;
            3:       v = VALUE_W'($urandom_range(0, 99));
            4:
            begin
                case ($urandom_range(0, 3))
                    0:       v = INT_MIN;
                    1:       v = INT_MAX;
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            5:
            begin
                power = 64'd1;
                repeat ($urandom_range(1, 31))
                begin
                    if (power * r <= 64'(INT_MAX))
                    begin
                        power = power * r;
                    end
                end
                v = VALUE_W'(power) - VALUE_W'($urandom_range(0, 1));
            end
            6:       v = {{16{1'b0}}, 16'($urandom)};
            default: v = $urandom >> $urandom_range(0, 31);
        endcase
        if ($urandom_range(0, 2) == 0)
        begin
            v = ~v + 1'b1;
        end
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        int                 random_sent;
        int                 phase;
        int                 count;
        logic [RADIX_W-1:0] r;
        logic [RADIX_W-1:0] radix_plan[$];

        board          = new();
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        burst_left     = 1;
        radix_settings = 1;
        radix_plan     = '{6'd10, 6'd16, 6'd2, 6'd36, 6'd8, 6'd3, 6'd32, 6'd0, 6'd7, 6'd10};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The first directed values use the reset radix of ten. They cover
        // zero, the sign in base ten, the one-digit and two-digit boundary,
        // and both extremes of the word. The most negative value must give
        // the full magnitude with no overflow.
        send_value('0);
        send_value(32'd1);
        send_value('1);
        send_value(32'd9);
        send_value(32'd10);
        send_value(-32'sd10);
        send_value(INT_MAX);
        send_value(INT_MIN);
        send_value(32'd100);
        send_value(-32'sd1234567890);

        // In the top radix the largest digit is 'V'. Negative values print as
        // their magnitude with no sign.
        set_radix(MAX_RADIX);
        send_value(32'd31);
        send_value(INT_MIN);
        send_value('1);
        send_value(32'd1023);

        // Base two gives the longest text, up to 32 characters.
        set_radix(MIN_RADIX);
        send_value(INT_MIN);
        send_value(INT_MAX);
        send_value(32'd5);

        set_radix(6'd16);
        send_value(32'hDEAD_BEEF);

        // Out-of-range settings at both ends and just beside the valid range.
        // Each must give one flagged empty result.
        set_radix(6'd0);
        send_value(32'd42);
        set_radix(6'd63);
        send_value(INT_MIN);
        set_radix(6'd1);
        send_value(32'd7);
        set_radix(6'd33);
        send_value('1);

        // Random phases. Each phase is a new radix with a batch of values.
        // Now and then the sender also waits mid-phase until the output
        // has caught up.
        random_sent = 0;
        phase       = 0;
        while (random_sent < RANDOM_VALUES)
        begin
            if (phase < radix_plan.size())
            begin
                r = radix_plan[phase];
            end
            else if ($urandom_range(0, 3) != 0)
            begin
                r = RADIX_W'($urandom_range(MIN_RADIX, MAX_RADIX));
            end
            else
            begin
                r = RADIX_W'($urandom_range(0, 63));
            end
            set_radix(r);
            count = (r < MIN_RADIX || r > MAX_RADIX) ? 6 : $urandom_range(20, 40);
            repeat (count)
            begin
                if (random_sent < RANDOM_VALUES)
                begin
                    send_value(random_value(r));
                    random_sent++;
                    if ($urandom_range(0, 29) == 0)
                    begin
                        drain_text();
                    end
                end
            end
            phase++;
        end

        // Let the last text come out, then allow a margin in which any
        // character that was not awaited would still be caught.
        drain_text();
        repeat (100) @(posedge clk);

        $display("Run covered %0d values over %0d radix settings, %0d characters checked.",
                 board.values_noted, radix_settings, board.chars_checked);
        $display("Out-of-range results seen: %0d, minus signs seen: %0d, errors: %0d.",
                 board.flagged_results, board.minus_signs, board.errors);
        if (board.errors == 0 && board.awaited_count() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* signed_to_radix_ascii.f */
+incdir+sv
sv/srtra_pkg.sv
sv/srtra_div.sv
sv/srtra_digit_buf.sv
sv/signed_to_radix_ascii.sv
sim/tb_signed_to_radix_ascii.sv
